>>> hdl/lpg_pkg.sv
`default_nettype none

package lpg_pkg;

    localparam int COORD_BITS_DEF = 11;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // back end status, seen by the top level checks
    typedef struct packed {
        logic active;
        logic line_load;
    } lpg_status_t;

    // width of one packed command: three flags, three coordinates, three error values
    function automatic int cmd_bits(input int cb);
        return 3 + 3 * cb + 3 * (cb + 3);
    endfunction

    function automatic int res_bits(input int cb);
        return 2 * cb + 1;
    endfunction

endpackage

`default_nettype wire

>>> hdl/lpg_fifo.sv
`default_nettype none

module lpg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  full,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/lpg_front.sv
`default_nettype none

module lpg_front #(
    parameter int COORD_BITS = 11
) (
    input  wire logic                                    op,
    input  wire logic [COORD_BITS-1:0]                   x_start,
    input  wire logic [COORD_BITS-1:0]                   y_start,
    input  wire logic [COORD_BITS-1:0]                   x_end,
    input  wire logic [COORD_BITS-1:0]                   y_end,
    output logic      [lpg_pkg::cmd_bits(COORD_BITS)-1:0] cmd
);

    import lpg_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int E  = CB + 3;

    typedef struct packed {
        logic                is_step;
        logic                major_is_y;
        logic                minor_dir_neg;
        logic [CB-1:0]       cur_x;
        logic [CB-1:0]       cur_y;
        logic [CB-1:0]       major_end;
        logic signed [E-1:0] err_init;
        logic signed [E-1:0] inc_up;
        logic signed [E-1:0] inc_dn;
    } cmd_t;

    cmd_t          c;
    logic          gt_x, lt_x, gt_y, lt_y;
    logic [CB-1:0] adx, ady, minor_d, major_d;
    logic          major_y, swap;
    logic [E-1:0]  twice_minor, twice_major;

    always_comb
    begin
        gt_x = x_start > x_end;
        lt_x = x_start < x_end;
        gt_y = y_start > y_end;
        lt_y = y_start < y_end;
        adx  = gt_x ? (x_start - x_end) : (x_end - x_start);
        ady  = gt_y ? (y_start - y_end) : (y_end - y_start);

        // ties go to the y axis, a single point included
        major_y = !(ady < adx);
        swap    = major_y ? gt_y : gt_x;
        minor_d = major_y ? adx : ady;
        major_d = major_y ? ady : adx;

        twice_minor = {2'b00, minor_d, 1'b0};
        twice_major = {2'b00, major_d, 1'b0};

        c.is_step       = (op == OP_STEP);
        c.major_is_y    = major_y;
        c.cur_x         = swap ? x_end : x_start;
        c.cur_y         = swap ? y_end : y_start;
        c.major_end     = major_y ? (swap ? y_start : y_end) : (swap ? x_start : x_end);
        c.minor_dir_neg = major_y ? (swap ? lt_x : gt_x) : (swap ? lt_y : gt_y);
        c.inc_up        = $signed(twice_minor);
        c.inc_dn        = $signed(twice_minor - twice_major);
        c.err_init      = $signed(twice_minor - {3'b000, major_d});
    end

    assign cmd = c;

endmodule

`default_nettype wire

>>> hdl/lpg_back.sv
`default_nettype none

module lpg_back #(
    parameter int COORD_BITS = 11
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    cmd_empty,
    input  wire logic [lpg_pkg::cmd_bits(COORD_BITS)-1:0] cmd,
    output logic                                         cmd_pop,
    input  wire logic                                    res_full,
    output logic                                         res_push,
    output logic      [lpg_pkg::res_bits(COORD_BITS)-1:0] res,
    output lpg_pkg::lpg_status_t                         status
);

    import lpg_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int E  = CB + 3;

    typedef struct packed {
        logic                is_step;
        logic                major_is_y;
        logic                minor_dir_neg;
        logic [CB-1:0]       cur_x;
        logic [CB-1:0]       cur_y;
        logic [CB-1:0]       major_end;
        logic signed [E-1:0] err_init;
        logic signed [E-1:0] inc_up;
        logic signed [E-1:0] inc_dn;
    } cmd_t;

    cmd_t c;

    logic                active_reg, active_next;
    logic                major_is_y_reg, major_is_y_next;
    logic                minor_dir_neg_reg, minor_dir_neg_next;
    logic [CB-1:0]       cur_x_reg, cur_x_next;
    logic [CB-1:0]       cur_y_reg, cur_y_next;
    logic [CB-1:0]       major_end_reg, major_end_next;
    logic signed [E-1:0] inc_up_reg, inc_up_next;
    logic signed [E-1:0] inc_dn_reg, inc_dn_next;
    logic signed [E-1:0] err_reg, err_next;
    logic                last;
    logic [CB-1:0]       minor_cur, minor_stepped;

    assign c       = cmd;
    assign cmd_pop = !cmd_empty && !res_full;
    assign last    = major_is_y_reg ? (cur_y_reg == major_end_reg)
                                    : (cur_x_reg == major_end_reg);

    assign minor_cur     = major_is_y_reg ? cur_x_reg : cur_y_reg;
    assign minor_stepped = minor_dir_neg_reg ? (minor_cur - 1'b1) : (minor_cur + 1'b1);

    assign res_push = cmd_pop && c.is_step && active_reg;
    assign res      = {cur_x_reg, cur_y_reg, last};

    assign status.active    = active_reg;
    assign status.line_load = cmd_pop && !c.is_step;

    always_comb
    begin
        active_next        = active_reg;
        major_is_y_next    = major_is_y_reg;
        minor_dir_neg_next = minor_dir_neg_reg;
        cur_x_next         = cur_x_reg;
        cur_y_next         = cur_y_reg;
        major_end_next     = major_end_reg;
        inc_up_next        = inc_up_reg;
        inc_dn_next        = inc_dn_reg;
        err_next           = err_reg;
        if (cmd_pop)
        begin
            if (!c.is_step)
            begin
                // a new line drops whatever line was in progress
                active_next        = 1'b1;
                major_is_y_next    = c.major_is_y;
                minor_dir_neg_next = c.minor_dir_neg;
                cur_x_next         = c.cur_x;
                cur_y_next         = c.cur_y;
                major_end_next     = c.major_end;
                inc_up_next        = c.inc_up;
                inc_dn_next        = c.inc_dn;
                err_next           = c.err_init;
            end
            else if (active_reg)
            begin
                if (last)
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    if (err_reg > 0)
                    begin
                        err_next = err_reg + inc_dn_reg;
                        if (major_is_y_reg)
                        begin
                            cur_x_next = minor_stepped;
                        end
                        else
                        begin
                            cur_y_next = minor_stepped;
                        end
                    end
                    else
                    begin
                        err_next = err_reg + inc_up_reg;
                    end
                    if (major_is_y_reg)
                    begin
                        cur_y_next = cur_y_reg + 1'b1;
                    end
                    else
                    begin
                        cur_x_next = cur_x_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg        <= 1'b0;
            major_is_y_reg    <= 1'b0;
            minor_dir_neg_reg <= 1'b0;
            cur_x_reg         <= '0;
            cur_y_reg         <= '0;
            major_end_reg     <= '0;
            inc_up_reg        <= '0;
            inc_dn_reg        <= '0;
            err_reg           <= '0;
        end
        else
        begin
            active_reg        <= active_next;
            major_is_y_reg    <= major_is_y_next;
            minor_dir_neg_reg <= minor_dir_neg_next;
            cur_x_reg         <= cur_x_next;
            cur_y_reg         <= cur_y_next;
            major_end_reg     <= major_end_next;
            inc_up_reg        <= inc_up_next;
            inc_dn_reg        <= inc_dn_next;
            err_reg           <= err_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/line_pixel_generator_core.sv
// channel   | transaction                       | fields
// ----------+-----------------------------------+-----------------------------------------
// input     | push high and full low at clk     | op, x_start, y_start, x_end, y_end
// result    | pop high and empty low at clk     | pixel_x, pixel_y, last_pixel
//
// one item a cycle sustained while the result queue has room; the error update in the back end sets the pace
// a pixel is written to the result queue in the same cycle that its step item is popped from the command queue
// and can be popped at the next edge; a start item gives no result
// both queues are two deep, so a stalled result side fills them and then
// raises full; rst_n clears the queues and drops any line in progress

`default_nettype none

module line_pixel_generator_core #(
    parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic                  op,
    input  wire logic [COORD_BITS-1:0] x_start,
    input  wire logic [COORD_BITS-1:0] y_start,
    input  wire logic [COORD_BITS-1:0] x_end,
    input  wire logic [COORD_BITS-1:0] y_end,
    output logic                       empty,
    input  wire logic                  pop,
    output logic      [COORD_BITS-1:0] pixel_x,
    output logic      [COORD_BITS-1:0] pixel_y,
    output logic                       last_pixel
);

    import lpg_pkg::*;

    localparam int CMD_W = cmd_bits(COORD_BITS);
    localparam int RES_W = res_bits(COORD_BITS);

    logic [CMD_W-1:0] front_cmd;
    logic [CMD_W-1:0] queued_cmd;
    logic             cmd_empty;
    logic             cmd_pop;
    logic [RES_W-1:0] back_res;
    logic [RES_W-1:0] head_res;
    logic             res_full;
    logic             res_push;
    lpg_status_t      status;

    lpg_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .op      (op),
        .x_start (x_start),
        .y_start (y_start),
        .x_end   (x_end),
        .y_end   (y_end),
        .cmd     (front_cmd)
    );

    lpg_fifo #(
        .WIDTH(CMD_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_cmd),
        .pop     (cmd_pop),
        .rd_data (queued_cmd),
        .full    (full),
        .empty   (cmd_empty)
    );

    lpg_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (queued_cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (back_res),
        .status    (status)
    );

    lpg_fifo #(
        .WIDTH(RES_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (back_res),
        .pop     (pop),
        .rd_data (head_res),
        .full    (res_full),
        .empty   (empty)
    );

    assign pixel_x    = head_res[RES_W-1 -: COORD_BITS];
    assign pixel_y    = head_res[COORD_BITS:1];
    assign last_pixel = head_res[0];

`ifndef SYNTH
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_push && res_full))
        else $error("result pushed into a full result queue");

    a_load_sets_active: assert property (@(posedge clk) disable iff (!rst_n)
        status.line_load |=> status.active)
        else $error("line not active after a start transaction");

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && back_res[0]) |=> !status.active)
        else $error("line still active after its final pixel");

    a_result_needs_line: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (status.active && cmd_pop))
        else $error("pixel produced without an active line");
`endif

endmodule

`default_nettype wire

>>> test/tb_line_pixel_generator_core.sv
`default_nettype none

module tb_line_pixel_generator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import lpg_pkg::*;

    localparam int CB         = COORD_BITS_DEF;
    localparam int CMAX       = (1 << CB) - 1;
    localparam int RAND_ITEMS = 800;
    localparam int QUIET_FROM = 300;
    localparam int QUIET_TO   = 420;
    localparam int IDLE_PCT   = 15;
    localparam int N_DIR      = 24;

    typedef logic [CB-1:0] coord_t;

    typedef struct packed {
        logic   op;
        coord_t xs;
        coord_t ys;
        coord_t xe;
        coord_t ye;
    } line_item_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   last;
    } pixel_t;

    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_PIXEL} chk_t;

    typedef struct packed {
        line_item_t item;
        chk_t       chk;
        pixel_t     pix;
    } dir_row_t;

    logic   clk        = 1'b0;
    logic   rst_n      = 1'b0;
    logic   push       = 1'b0;
    logic   op         = OP_STEP;
    coord_t x_start    = '0;
    coord_t y_start    = '0;
    coord_t x_end      = '0;
    coord_t y_end      = '0;
    logic   pop        = 1'b0;
    logic   full;
    logic   empty;
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;

    bit     steady = 1'b0;
    int     fails  = 0;
    pixel_t pixels_due [$];

    // rasteriser state as the block should hold it
    logic                 line_on   = 1'b0;
    logic                 major_y   = 1'b0;
    logic                 minor_neg = 1'b0;
    coord_t               cur_x     = '0;
    coord_t               cur_y     = '0;
    coord_t               major_stop = '0;
    logic signed [CB+1:0] two_minor = '0;
    logic signed [CB+1:0] two_major = '0;
    logic signed [CB+2:0] err       = '0;

    dir_row_t dir_rows [N_DIR] = '{
        '{'{OP_STEP,  0, 0, 0, 0},             CHK_NONE,  '{0, 0, 0}},
        '{'{OP_START, 0, 0, 0, 0},             CHK_NONE,  '{0, 0, 0}},
        '{'{OP_STEP,  2047, 2047, 2047, 2047}, CHK_PIXEL, '{0, 0, 1}},
        '{'{OP_STEP,  0, 0, 0, 0},             CHK_NONE,  '{0, 0, 0}},
        '{'{OP_START, 2047, 2047, 2047, 2047}, CHK_NONE,  '{0, 0, 0}},
        '{'{OP_STEP,  0, 0, 0, 0},             CHK_PIXEL, '{2047, 2047, 1}},
        '{'{OP_START, 0, 0, 2047, 0},          CHK_NONE,  '{0, 0, 0}},
        '{'{OP_STEP,  1365, 682, 1365, 682},   CHK_PIXEL, '{0, 0, 0}},
        '{'{OP_STEP,  682, 1365, 682, 1365},   CHK_MODEL, '{0, 0, 0}},
        '{'{OP_START, 2047, 2047, 0, 0},       CHK_NONE,  '{0, 0, 0}},
        '{'{OP_STEP,  0, 0, 0, 0},             CHK_PIXEL, '{0, 0, 0}},
        '{'{OP_STEP,  0, 0, 0, 0},             CHK_MODEL, '{0, 0, 0}},
        '{'{OP_START, 0, 2047, 2047, 2046},    CHK_NONE,  '{0, 0, 0}},
        '{'{OP_STEP,  0, 0, 0, 0},             CHK_PIXEL, '{0, 2047, 0}},
        '{'{OP_STEP,  0, 0, 0, 0},             CHK_MODEL, '{0, 0, 0}},
        '{'{OP_START, 1, 3, 4, 0},             CHK_NONE,  '{0, 0, 0}},
        '{'{OP_STEP,  0, 0, 0, 0},             CHK_MODEL, '{0, 0, 0}},
        '{'{OP_STEP,  0, 0, 0, 0},             CHK_MODEL, '{0, 0, 0}},
        '{'{OP_STEP,  0, 0, 0, 0},             CHK_MODEL, '{0, 0, 0}},
        '{'{OP_STEP,  0, 0, 0, 0},             CHK_MODEL, '{0, 0, 0}},
        '{'{OP_STEP,  0, 0, 0, 0},             CHK_NONE,  '{0, 0, 0}},
        '{'{OP_START, 10, 20, 13, 10},         CHK_NONE,  '{0, 0, 0}},
        '{'{OP_STEP,  0, 0, 0, 0},             CHK_MODEL, '{0, 0, 0}},
        '{'{OP_STEP,  0, 0, 0, 0},             CHK_MODEL, '{0, 0, 0}}
    };

    line_pixel_generator_core #(
        .COORD_BITS (CB)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .op         (op),
        .x_start    (x_start),
        .y_start    (y_start),
        .x_end      (x_end),
        .y_end      (y_end),
        .empty      (empty),
        .pop        (pop),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (last_pixel)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("line_pixel_generator_core regression: fail");
        $finish;
    end

    // bresenham model: a start item loads the line, and each step item gives one pixel while a line is in progress
    task automatic raster_pixel(input line_item_t it, output bit got, output pixel_t px);
        coord_t ax;
        coord_t ay;
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
        logic   reach;
        got = 1'b0;
        px  = '0;
        if (it.op == OP_START) begin
            ax = (it.xs > it.xe) ? it.xs - it.xe : it.xe - it.xs;
            ay = (it.ys > it.ye) ? it.ys - it.ye : it.ye - it.ys;
            major_y = !(ay < ax);
            // order the ends so the major coordinate climbs
            if (major_y ? (it.ys > it.ye) : (it.xs > it.xe)) begin
                x0 = it.xe;
                y0 = it.ye;
                x1 = it.xs;
                y1 = it.ys;
            end
            else begin
                x0 = it.xs;
                y0 = it.ys;
                x1 = it.xe;
                y1 = it.ye;
            end
            cur_x = x0;
            cur_y = y0;
            if (major_y) begin
                major_stop = y1;
                minor_neg  = x1 < x0;
                two_minor  = {1'b0, ax, 1'b0};
                two_major  = {1'b0, ay, 1'b0};
            end
            else begin
                major_stop = x1;
                minor_neg  = y1 < y0;
                two_minor  = {1'b0, ay, 1'b0};
                two_major  = {1'b0, ax, 1'b0};
            end
            err     = two_minor - (two_major >>> 1);
            line_on = 1'b1;
        end
        else if (line_on) begin
            reach = major_y ? (cur_y == major_stop) : (cur_x == major_stop);
            got   = 1'b1;
            px    = '{cur_x, cur_y, reach};
            if (reach) begin
                line_on = 1'b0;
            end
            else begin
                if (err > 0) begin
                    if (major_y)
                        cur_x = minor_neg ? cur_x - 1'b1 : cur_x + 1'b1;
                    else
                        cur_y = minor_neg ? cur_y - 1'b1 : cur_y + 1'b1;
                    err = err + two_minor - two_major;
                end
                else begin
                    err = err + two_minor;
                end
                if (major_y)
                    cur_y = cur_y + 1'b1;
                else
                    cur_x = cur_x + 1'b1;
            end
        end
    endtask

    function automatic line_item_t random_item(input logic op_code);
        line_item_t it;
        it.op = op_code;
        it.xs = coord_t'($urandom_range(CMAX));
        it.ys = coord_t'($urandom_range(CMAX));
        it.xe = coord_t'($urandom_range(CMAX));
        it.ye = coord_t'($urandom_range(CMAX));
        return it;
    endfunction

    function automatic int near_coord(input int c, input int mag);
        int d;
        d = $urandom_range(1) ? -mag : mag;
        if (c + d > CMAX || c + d < 0)
            d = -d;
        return c + d;
    endfunction

    task automatic send_item(input line_item_t it, input chk_t chk, input pixel_t typed);
        bit     got;
        pixel_t px;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        op      <= it.op;
        x_start <= it.xs;
        y_start <= it.ys;
        x_end   <= it.xe;
        y_end   <= it.ye;
        do
            @(posedge clk);
        while (full);
        raster_pixel(it, got, px);
        if (chk == CHK_PIXEL)
            pixels_due.push_back(typed);
        else if (chk == CHK_MODEL && got)
            pixels_due.push_back(px);
    endtask

    // one start transaction and its steps, mostly short lines run to the end
    task automatic draw_line(inout int count);
        line_item_t it;
        int         x0;
        int         y0;
        int         x1;
        int         y1;
        int         mx;
        int         my;
        int         span;
        int         steps;
        it = random_item(OP_START);
        if ($urandom_range(9) != 0) begin
            span = $urandom_range(24);
            mx   = $urandom_range(span);
            my   = ($urandom_range(3) == 0) ? mx : $urandom_range(span);
            x0   = int'(it.xs);
            y0   = int'(it.ys);
            x1   = near_coord(x0, mx);
            y1   = near_coord(y0, my);
            it.xe = coord_t'(x1);
            it.ye = coord_t'(y1);
            steps = ((mx > my) ? mx : my) + 1;
            // now and then abandon the line part way
            if ($urandom_range(9) == 0)
                steps = $urandom_range(steps - 1);
        end
        else begin
            steps = $urandom_range(1, 40);
        end
        send_item(it, CHK_MODEL, '0);
        count++;
        repeat (steps) begin
            send_item(random_item(OP_STEP), CHK_MODEL, '0);
            count++;
        end
    endtask

    initial
    begin
        int count;
        int pick;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].chk, dir_rows[i].pix);

        count = 0;
        while (count < RAND_ITEMS) begin
            steady = (count >= QUIET_FROM && count < QUIET_TO);
            pick   = $urandom_range(99);
            if (pick < 8) begin
                // stray step outside draw_line; a line may still be in progress
                send_item(random_item(OP_STEP), CHK_MODEL, '0);
            end
            else if (pick < 12) begin
                send_item(random_item(OP_START), CHK_MODEL, '0);
                count++;
            end
            else begin
                draw_line(count);
            end
        end
        steady = 1'b0;
        push <= 1'b0;

        while (pixels_due.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (fails == 0)
            $display("line_pixel_generator_core regression: pass");
        else
            $display("line_pixel_generator_core regression: fail");
        $finish;
    end

    // result side: random pop (held high while steady), compare each pixel transaction in order
    initial
    begin
        pixel_t want;
        forever begin
            @(posedge clk);
            if (rst_n && pop && !empty) begin
                if (pixels_due.size() == 0) begin
                    $display("%0t: unexpected pixel x=%0d y=%0d last=%0d",
                             $time, pixel_x, pixel_y, last_pixel);
                    fails++;
                end
                else begin
                    want = pixels_due.pop_front();
                    if (pixel_x !== want.x || pixel_y !== want.y || last_pixel !== want.last)
                    begin
                        $display("%0t: pixel mismatch exp x=%0d y=%0d last=%0d got x=%0d y=%0d last=%0d",
                                 $time, want.x, want.y, want.last,
                                 pixel_x, pixel_y, last_pixel);
                        fails++;
                    end
                end
            end
            pop <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

endmodule

`default_nettype wire
